// ===== rtl/bvh_nn_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_nn_pkg : shared types and constants
// Sizes, action codes and scan-control states for the window neighbour search.
// ---------------------------------------------------------------------------
package bvh_nn_pkg;

  localparam int MAX_NODES         = 1024;
  localparam int WINDOW_RADIUS_DEF = 14;
  localparam int COORD_BITS        = 16;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int COST_W  = 2 * (COORD_BITS + 1);
  localparam int FIFO_DEPTH = 2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN,
    ST_DRAIN,
    ST_BACK,
    ST_OUT
  } scan_state_t;

endpackage

// ===== rtl/bvh_nn_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_nn_front : request intake and box store
// Loads are written straight into the box memory; queries go into a short
// queue for the search engine. The memory read port is lent to the engine.
// ---------------------------------------------------------------------------
module bvh_nn_front
  import bvh_nn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [IDX_W-1:0]        in_index,
  input  logic [6*COORD_BITS-1:0] in_box,
  // engine still reading the table for a query
  input  logic                    eng_busy,
  // query queue towards the engine
  output logic                    q_valid,
  input  logic                    q_pop,
  output logic [IDX_W-1:0]        q_index,
  // read port for the engine, data registered and valid the cycle after the address
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [6*COORD_BITS-1:0] rd_box
);

  logic [6*COORD_BITS-1:0] box_mem [MAX_NODES];
  logic [IDX_W-1:0] fifo_r [FIFO_DEPTH];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, wr_en;

  // a load waits until no earlier query is queued or still reading the table
  assign in_ready = (in_action == ACT_QUERY) ? (cnt_r != 2'(FIFO_DEPTH)) :
                    ((cnt_r == 2'd0) && !eng_busy);
  assign push     = in_valid && in_ready && (in_action == ACT_QUERY);
  assign wr_en    = in_valid && in_ready && (in_action == ACT_LOAD) &&
                    ({1'b0, in_index} < (IDX_W+1)'(MAX_NODES));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_index  = fifo_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= in_index;
  end

  always_ff @(posedge clk) begin
    if (wr_en) box_mem[in_index] <= in_box;
    rd_box <= box_mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(FIFO_DEPTH)) else $error("query queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(FIFO_DEPTH)) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

// ===== rtl/bvh_nn_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_nn_engine : window search sequencer
// Reads the centre box, then one candidate per cycle, costs each union in a
// two-stage pipe and keeps the minimum. Runs a second pass from the winner, if found.
// ---------------------------------------------------------------------------
module bvh_nn_engine
  import bvh_nn_pkg::*;
#(
  parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        node_count,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [IDX_W-1:0]        q_index,
  output logic                    busy,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic [6*COORD_BITS-1:0] rd_box,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [IDX_W-1:0]        res_queried,
  output logic [IDX_W-1:0]        res_neighbor,
  output logic [COST_W-1:0]       res_cost,
  output logic                    res_merge
);

  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;

  scan_state_t st_r, st_nxt;
  logic              pass_r, pass_nxt;      // 0 forward, 1 back search
  logic [IDX_W-1:0]  qi_r, qi_nxt;          // original query
  logic [IDX_W-1:0]  ci_r, ci_nxt;          // centre of current pass
  logic [IDX_W+1:0]  j_r, j_nxt, hi_r, hi_nxt;
  logic [6*COORD_BITS-1:0] cbox_r;
  logic              cload;
  // pipe: s0 = read issued, s1 = box back and extents, s2 = cost
  logic              v1_r, v1_nxt, v2_r;
  logic [IDX_W-1:0]  j1_r, j1_nxt, j2_r, j3_r;
  logic [EW-1:0]     e_r [3];
  logic [PW-1:0]     p_r [3];
  logic              v3_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [COST_W-1:0] bcost_r, bcost_nxt;
  logic [COST_W-1:0] sum;
  logic [IDX_W-1:0]  nb_r, nb_nxt;
  logic [COST_W-1:0] ncost_r, ncost_nxt;
  logic              merge_r, merge_nxt;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W+1:0]  lo_w, hi_w;

  assign cnt = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  // table reads still to come for the current query
  assign busy = !(st_r inside {ST_IDLE, ST_OUT});

  // window bounds for a centre c
  function automatic logic [IDX_W+1:0] win_lo(input logic [IDX_W-1:0] c);
    return ({2'b0, c} > (IDX_W+2)'(WINDOW_RADIUS)) ?
           {2'b0, c} - (IDX_W+2)'(WINDOW_RADIUS) : '0;
  endfunction
  function automatic logic [IDX_W+1:0] win_hi(input logic [IDX_W-1:0] c,
                                              input logic [CNT_W-1:0] n);
    logic [IDX_W+1:0] h;
    h = {2'b0, c} + (IDX_W+2)'(WINDOW_RADIUS + 1);
    return (h > (IDX_W+2)'(n)) ? (IDX_W+2)'(n) : h;
  endfunction

  // stage 1: union extents against the centre box
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [COORD_BITS-1:0] al, ah, bl, bh, l, h;
      al = cbox_r[k*COORD_BITS +: COORD_BITS];
      ah = cbox_r[(k+3)*COORD_BITS +: COORD_BITS];
      bl = rd_box[k*COORD_BITS +: COORD_BITS];
      bh = rd_box[(k+3)*COORD_BITS +: COORD_BITS];
      l  = (al < bl) ? al : bl;
      h  = (ah > bh) ? ah : bh;
      e_r[k] <= (h > l) ? EW'($signed({h[COORD_BITS-1], h}) -
                              $signed({l[COORD_BITS-1], l})) : '0;
    end
    j2_r <= j1_r;
    // stage 2: products
    for (int k = 0; k < 3; k++) p_r[k] <= e_r[k] * e_r[(k+1)%3];
    j3_r <= j2_r;
    if (cload) cbox_r <= rd_box;
  end

  assign sum = COST_W'(p_r[0]) + COST_W'(p_r[1]) + COST_W'(p_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      st_r <= st_nxt; v1_r <= v1_nxt; v2_r <= v1_r && !cload; v3_r <= v2_r;
    end
    pass_r <= pass_nxt; qi_r <= qi_nxt; ci_r <= ci_nxt; j_r <= j_nxt;
    hi_r <= hi_nxt; j1_r <= j1_nxt; found_r <= found_nxt; best_r <= best_nxt;
    bcost_r <= bcost_nxt; nb_r <= nb_nxt; ncost_r <= ncost_nxt;
    merge_r <= merge_nxt;
  end

  always_comb begin
    st_nxt = st_r; pass_nxt = pass_r; qi_nxt = qi_r; ci_nxt = ci_r;
    j_nxt = j_r; hi_nxt = hi_r; j1_nxt = j1_r; v1_nxt = 1'b0;
    found_nxt = found_r; best_nxt = best_r; bcost_nxt = bcost_r;
    nb_nxt = nb_r; ncost_nxt = ncost_r; merge_nxt = merge_r;
    q_pop = 1'b0; rd_addr = ci_r; cload = 1'b0;
    lo_w = win_lo(ci_r); hi_w = win_hi(ci_r, cnt);
    res_valid = 1'b0;
    // minimum tracking off the pipe end
    if (v3_r && (!found_r || sum < bcost_r)) begin
      found_nxt = 1'b1; bcost_nxt = sum; best_nxt = j3_r;
    end
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; qi_nxt = q_index; ci_nxt = q_index; pass_nxt = 1'b0;
          rd_addr = q_index; v1_nxt = 1'b1; st_nxt = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        cload = 1'b1; found_nxt = 1'b0;
        j_nxt = lo_w; hi_nxt = hi_w; st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_r >= hi_r) begin
          st_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
          if (j_r[IDX_W-1:0] != ci_r) begin
            rd_addr = j_r[IDX_W-1:0]; j1_nxt = j_r[IDX_W-1:0]; v1_nxt = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) st_nxt = ST_BACK;
      end
      ST_BACK: begin
        if (!pass_r) begin
          if (!found_r) begin
            nb_nxt = qi_r; ncost_nxt = '0; merge_nxt = 1'b0; st_nxt = ST_OUT;
          end else begin
            nb_nxt = best_r; ncost_nxt = bcost_r; pass_nxt = 1'b1;
            ci_nxt = best_r; rd_addr = best_r; v1_nxt = 1'b1;
            st_nxt = ST_CENTRE;
          end
        end else begin
          merge_nxt = found_r && (best_r == qi_r) && (qi_r < nb_r);
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign res_queried  = qi_r;
  assign res_neighbor = nb_r;
  assign res_cost     = ncost_r;
  assign res_merge    = merge_r;

  a_merge_mutual: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_merge) |-> (res_queried < res_neighbor))
    else $error("merge without ordered pair");
  a_empty_cost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_neighbor == res_queried) |-> (res_cost == '0 && !res_merge))
    else $error("self neighbour with cost");
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !v3_r) else $error("pipe busy while idle");

endmodule

// ===== rtl/bvh_nn_out.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_nn_out : result register
// One-entry output register so the engine can return to idle early.
// ---------------------------------------------------------------------------
module bvh_nn_out
  import bvh_nn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  logic [IDX_W-1:0]  res_queried,
  input  logic [IDX_W-1:0]  res_neighbor,
  input  logic [COST_W-1:0] res_cost,
  input  logic              res_merge,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata
);

  logic v_r;
  logic [55:0] d_r;

  assign res_ready  = !v_r || out_tready;
  assign out_tvalid = v_r;
  assign out_tdata  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (res_ready) v_r <= res_valid;
    if (res_ready && res_valid)
      d_r <= {1'b0, res_merge, res_cost, res_neighbor, res_queried};
  end

endmodule

// ===== rtl/bvh_window_nearest_neighbor_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_window_nearest_neighbor_core : window nearest-neighbour search
// Box table with PLOC-style pair search over a clipped window.
// ---------------------------------------------------------------------------
// A load (tuser 0) writes one box. A query (tuser 1) scans the clipped
// window around node i, one stored box per cycle through the single memory
// read port, then, if a neighbour was found, scans again around the winner;
// each pass also reads the centre box and drains the cost pipe. Two
// queries can be queued behind the running one; a load is held off until no
// query is queued or still reading the table, so requests act in order.
module bvh_window_nearest_neighbor_core
  import bvh_nn_pkg::*;
#(
  parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // node_index, min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  logic [((IDX_W+6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // action
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // queried_index, neighbor_index, best_cost, merge_flag, zero pad
  output logic [55:0]                   out_tdata,
  input  logic                          cfg_we,
  input  logic [CNT_W-1:0]              cfg_wdata
);

  logic [CNT_W-1:0] node_count_r;
  logic q_valid, q_pop, eng_busy;
  logic [IDX_W-1:0] q_index, rd_addr, rq, rn;
  logic [6*COORD_BITS-1:0] rd_box;
  logic rv, rr, rm;
  logic [COST_W-1:0] rc;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= CNT_W'(2);
    else if (cfg_we) node_count_r <= cfg_wdata;
  end

  bvh_nn_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_action(in_tuser), .in_index(in_tdata[IDX_W-1:0]),
    .in_box(in_tdata[IDX_W +: 6*COORD_BITS]), .eng_busy,
    .q_valid, .q_pop, .q_index, .rd_addr, .rd_box
  );

  bvh_nn_engine #(.WINDOW_RADIUS(WINDOW_RADIUS)) u_engine (
    .clk, .rst_n, .node_count(node_count_r), .q_valid, .q_pop, .q_index,
    .busy(eng_busy), .rd_addr, .rd_box, .res_valid(rv), .res_ready(rr),
    .res_queried(rq), .res_neighbor(rn), .res_cost(rc), .res_merge(rm)
  );

  bvh_nn_out u_out (
    .clk, .rst_n, .res_valid(rv), .res_ready(rr), .res_queried(rq),
    .res_neighbor(rn), .res_cost(rc), .res_merge(rm),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

// ===== tb/bvh_window_nearest_neighbor_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvh_window_nearest_neighbor_core_tb : self-checking bench for the pair search
// Loads boxes, queries nodes over several node counts and compares every
// result with a behavioural window search kept alongside the table.
// ---------------------------------------------------------------------------
module bvh_window_nearest_neighbor_core_tb;
  import bvh_nn_pkg::*;

  localparam int NODES  = 1024;
  localparam int RADIUS = 14;
  localparam int DATA_W = ((IDX_W + 6 * 16 + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [IDX_W-1:0]  queried;
    logic [IDX_W-1:0]  neighbor;
    logic [COST_W-1:0] cost;
    logic              merge;
  } pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tuser = ACT_LOAD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  logic signed [15:0] box_lo [NODES][3];
  logic signed [15:0] box_hi [NODES][3];
  logic [CNT_W-1:0]   active_nodes = CNT_W'(2);
  pair_t              pending_pairs[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;

  bvh_window_nearest_neighbor_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --- prediction ---------------------------------------------------------
  function automatic longint unsigned union_area(int a, int b);
    longint unsigned ext [3];
    int lo, hi;
    for (int k = 0; k < 3; k++) begin
      lo = (box_lo[a][k] < box_lo[b][k]) ? box_lo[a][k] : box_lo[b][k];
      hi = (box_hi[a][k] > box_hi[b][k]) ? box_hi[a][k] : box_hi[b][k];
      ext[k] = (hi > lo) ? longint'(hi - lo) : 0;
    end
    return ext[0] * ext[1] + ext[1] * ext[2] + ext[2] * ext[0];
  endfunction

  function automatic bit window_best(int i, output int best, output longint unsigned cost);
    int lo, hi, cnt;
    bit found;
    longint unsigned c;
    found = 1'b0;
    best = i;
    cost = 0;
    cnt = (active_nodes > NODES) ? NODES : active_nodes;
    lo = (i > RADIUS) ? i - RADIUS : 0;
    hi = (i + RADIUS + 1 > cnt) ? cnt : i + RADIUS + 1;
    for (int j = lo; j < hi; j++) begin
      if (j != i) begin
        c = union_area(i, j);
        if (!found || c < cost) begin
          found = 1'b1;
          cost = c;
          best = j;
        end
      end
    end
    return found;
  endfunction

  function automatic pair_t predict_pair(int i);
    pair_t p;
    int nb, back;
    longint unsigned c, back_c;
    p.queried = IDX_W'(i);
    p.merge = 1'b0;
    if (window_best(i, nb, c)) begin
      p.neighbor = IDX_W'(nb);
      p.cost = c[COST_W-1:0];
      if (window_best(nb, back, back_c) && back == i && i < nb) p.merge = 1'b1;
    end else begin
      p.neighbor = IDX_W'(i);
      p.cost = '0;
    end
    return p;
  endfunction

  // --- driving ------------------------------------------------------------
  // Called and returns at a falling edge.
  task automatic send_request(logic act, int idx, logic signed [15:0] lo [3],
                              logic signed [15:0] hi [3]);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = '0;
    in_tdata[9:0] = IDX_W'(idx);
    for (int k = 0; k < 3; k++) begin
      in_tdata[10 + 16 * k +: 16] = lo[k];
      in_tdata[58 + 16 * k +: 16] = hi[k];
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[idx][k] = lo[k];
        box_hi[idx][k] = hi[k];
      end
    end else begin
      pending_pairs.push_back(predict_pair(idx));
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic load_box(int idx, int x0, int y0, int z0, int x1, int y1, int z1);
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    lo = '{16'(x0), 16'(y0), 16'(z0)};
    hi = '{16'(x1), 16'(y1), 16'(z1)};
    send_request(ACT_LOAD, idx, lo, hi);
  endtask

  task automatic query_node(int idx);
    logic signed [15:0] z [3];
    z = '{16'($urandom), 16'($urandom), 16'($urandom)};
    send_request(ACT_QUERY, idx, z, z);
  endtask

  task automatic load_random(int idx);
    int cx, cy, cz, r;
    if ($urandom_range(0, 4) == 0) begin
      load_box(idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      r  = ($urandom_range(0, 2) == 0) ? 3 : 2000;
      cx = $urandom_range(0, 20000) - 10000;
      cy = $urandom_range(0, 20000) - 10000;
      cz = $urandom_range(0, 20000) - 10000;
      load_box(idx, cx - $urandom_range(0, r), cy - $urandom_range(0, r),
               cz - $urandom_range(0, r), cx + $urandom_range(0, r),
               cy + $urandom_range(0, r), cz + $urandom_range(0, r));
    end
  endtask

  task automatic drain_results();
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_node_count(int n);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = CNT_W'(n);
    @(negedge clk);
    cfg_we = 1'b0;
    active_nodes = CNT_W'(n);
  endtask

  // --- tests --------------------------------------------------------------
  task automatic test_fill_table();
    for (int i = 0; i < NODES; i++) load_random(i);
  endtask

  task automatic test_directed();
    set_node_count(2);
    load_box(0, -32768, -32768, -32768, 32767, 32767, 32767);
    load_box(1, 0, 0, 0, 0, 0, 0);
    query_node(0);                      // full-range union
    query_node(1);
    query_node(1023);                   // far beyond the nodes in use
    set_node_count(0);
    query_node(0);                      // empty window
    set_node_count(1);
    query_node(0);
    drain_results();
    load_box(2, 5, 5, 5, -5, -5, -5);   // inverted extents
    load_box(3, 5, 5, 5, -5, -5, -5);
    load_box(4, 1, 1, 1, 2, 2, 2);
    load_box(5, 1, 1, 1, 2, 2, 2);      // tie with entry 4
    load_box(6, 1, 1, 1, 2, 2, 2);
    set_node_count(7);
    query_node(2);
    query_node(5);
    query_node(6);
    query_node(20);                     // not in use, window clipped
    set_node_count(1024);
    query_node(1023);
    query_node(0);
    query_node(512);
    set_node_count(2047);               // saturates to the table size
    query_node(1020);
    query_node(14);
  endtask

  task automatic test_random_phases(int phases);
    int n, cnt, span;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: cnt = $urandom_range(0, 3);
        1: cnt = ($urandom_range(0, 1) == 0) ? 1024 : $urandom_range(1025, 2047);
        default: cnt = $urandom_range(4, 64);
      endcase
      set_node_count(cnt);
      span = (cnt > 1024) ? 1024 : ((cnt < 2) ? 2 : cnt);
      n = $urandom_range(0, 8);
      for (int k = 0; k < n; k++) load_random($urandom_range(0, span - 1));
      n = $urandom_range(6, 20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) query_node($urandom_range(0, 1023));
        else query_node($urandom_range(0, span - 1));
      end
    end
  endtask

  task automatic test_output_stall();
    set_node_count(40);
    hold_req = 1'b1;
    for (int k = 0; k < 10; k++) query_node($urandom_range(0, 39));
    drain_results();
  endtask

  // --- result side --------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pair_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[9:0], out_tdata[19:10], out_tdata[53:20], out_tdata[54]};
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_fill_table();
    test_directed();
    test_output_stall();
    test_random_phases(45);
    calm = 1'b1;
    test_random_phases(8);
    drain_results();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
